// ----- rtl/bars_pkg.sv -----
// shared types, constants and helpers of the bridge converter serial reader
`default_nettype none

package bars_pkg;

    localparam int PIN_W        = 3;
    localparam int CHAN_W       = 2;
    localparam int SAMPLE_W     = 24;
    localparam int TIMEOUT_W    = 16;
    localparam int GAIN_W       = 2;
    localparam int BITCNT_W     = 5;
    localparam int EXTRA_W      = 2;
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int CHANNELS_DEF = 3;
    localparam int QUEUE_DEPTH  = 2;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN    = 1'b0,
        CFG_TIMEOUT = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        ITEM_TICK  = 2'd0,
        ITEM_START = 2'd1,
        ITEM_BAD   = 2'd2
    } item_kind_t;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_WAIT  = 3'd1,
        PH_HIGH  = 3'd2,
        PH_LOW   = 3'd3,
        PH_XHIGH = 3'd4,
        PH_XLOW  = 3'd5
    } phase_t;

    typedef enum logic [GAIN_W-1:0] {
        GAIN_128   = 2'd0,
        GAIN_32    = 2'd1,
        GAIN_64    = 2'd2,
        GAIN_128_B = 2'd3
    } gain_t;

    typedef struct packed {
        item_kind_t          kind;
        logic [CHAN_W-1:0]   channel;
        logic [PIN_W-1:0]    pins;
    } bars_item_t;

    // extra clock pulses after the data bits pick the next gain
    function automatic logic [EXTRA_W-1:0] pulses_for_gain(input logic [GAIN_W-1:0] gain);
        logic [EXTRA_W-1:0] pulses;
        case (gain)
            GAIN_32: pulses = 2'd2;
            GAIN_64: pulses = 2'd3;
            default: pulses = 2'd1;
        endcase
        return pulses;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/bars_req_if.sv -----
// request channel: one tick or start word per handshake
`default_nettype none

interface bars_req_if import bars_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                req_type;
    logic [CHAN_W-1:0]   channel;
    logic [PIN_W-1:0]    data_pins;

    modport source (output valid, output req_type, output channel, output data_pins,
                    input ready);
    modport sink   (input valid, input req_type, input channel, input data_pins,
                    output ready);
endinterface

`default_nettype wire

// ----- rtl/bars_res_if.sv -----
// result channel: one status word per request
`default_nettype none

interface bars_res_if import bars_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [PIN_W-1:0]           clock_pins;
    logic                       busy_res;
    logic                       done_res;
    logic                       read_ok;
    logic signed [SAMPLE_W-1:0] sample;
    logic [PIN_W-1:0]           found_mask;

    modport source (output valid, output clock_pins, output busy_res, output done_res,
                    output read_ok, output sample, output found_mask, input ready);
    modport sink   (input valid, input clock_pins, input busy_res, input done_res,
                    input read_ok, input sample, input found_mask, output ready);
endinterface

`default_nettype wire

// ----- rtl/bars_cfg_if.sv -----
// configuration write channel
`default_nettype none

interface bars_cfg_if import bars_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/bridge_adc_serial_reader_unit.sv -----
// a request word's result passes the queue and then the result register before it is valid
// throughput: one word per cycle unless the queue is full; back end likewise unless result stalls
// a two-word queue parts front and back, and a result register parts the output side
// a read spans about 50 ticks plus the wait for the data line, one tick per half period
// reset (async, active low) clears the sequencer, found flags and queue; gain 128, timeout 10000
`default_nettype none

module bridge_adc_serial_reader_unit import bars_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF,
    parameter int DEPTH    = QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    bars_req_if.sink    request,
    bars_res_if.source  result,
    bars_cfg_if.sink    cfg
);

    logic        push;
    logic        full;
    logic        pop;
    logic        q_valid;
    bars_item_t  item_in;
    bars_item_t  item_out;

    bars_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .request (request),
        .full    (full),
        .push    (push),
        .item    (item_in)
    );

    bars_queue #(
        .DEPTH (DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .item_in  (item_in),
        .full     (full),
        .pop      (pop),
        .valid    (q_valid),
        .item_out (item_out)
    );

    bars_back #(
        .CHANNELS (CHANNELS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_item  (item_out),
        .q_pop   (pop),
        .result  (result),
        .cfg     (cfg)
    );

endmodule

`default_nettype wire

// ----- rtl/bars_front.sv -----
// front end: accepts request words and classifies them for the queue
`default_nettype none

module bars_front import bars_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    bars_req_if.sink    request,
    input  logic        full,
    output logic        push,
    output bars_item_t  item
);

    always_comb
    begin
        request.ready = !full;
        push          = request.valid && !full;
        item.channel  = request.channel;
        item.pins     = request.data_pins;
        if (!request.req_type)
        begin
            item.kind = ITEM_TICK;
        end
        else if (32'(request.channel) >= CHANNELS)
        begin
            item.kind = ITEM_BAD;
        end
        else
        begin
            item.kind = ITEM_START;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bars_queue.sv -----
// short queue of classified words between front and back
`default_nettype none

module bars_queue import bars_pkg::*; #(
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  bars_item_t  item_in,
    output logic        full,
    input  logic        pop,
    output logic        valid,
    output bars_item_t  item_out
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    bars_item_t         slots_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign item_out = slots_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/bars_back.sv -----
// back end: read sequencer, configuration registers and result register
`default_nettype none

module bars_back import bars_pkg::*; #(
    parameter int CHANNELS = CHANNELS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    input  bars_item_t  q_item,
    output logic        q_pop,
    bars_res_if.source  result,
    bars_cfg_if.sink    cfg
);

    localparam logic [PIN_W-1:0] CH_MASK = PIN_W'((1 << CHANNELS) - 1);

    logic [GAIN_W-1:0]      gain_reg;
    logic [TIMEOUT_W-1:0]   timeout_reg;

    phase_t                 phase_reg, phase_next;
    logic [BITCNT_W-1:0]    bit_count_reg, bit_count_next;
    logic [EXTRA_W-1:0]     extra_reg, extra_next;
    logic [SAMPLE_W-1:0]    shift_reg, shift_next;
    logic [TIMEOUT_W-1:0]   wait_reg, wait_next;
    logic [CHAN_W-1:0]      chan_reg, chan_next;
    logic [PIN_W-1:0]       found_reg, found_next;

    logic                   out_valid_reg;
    logic [PIN_W-1:0]       clock_pins_reg, clock_pins_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic                   ok_reg, ok_next;
    logic [SAMPLE_W-1:0]    sample_reg, sample_next;
    logic [PIN_W-1:0]       found_out_reg, found_out_next;

    logic                   step;
    logic [PIN_W-1:0]       chan_bit, chan_bit_next;
    logic                   line;
    logic [TIMEOUT_W-1:0]   wait_inc;
    logic [BITCNT_W-1:0]    bit_inc;

    // one word is processed whenever the result register is free or draining
    assign step  = q_valid && (!out_valid_reg || result.ready);
    assign q_pop = step;

    assign chan_bit      = (chan_reg < CHAN_W'(PIN_W)) ? PIN_W'(1) << chan_reg : '0;
    assign chan_bit_next = (chan_next < CHAN_W'(PIN_W)) ? PIN_W'(1) << chan_next : '0;
    assign line          = |(q_item.pins & chan_bit);
    assign wait_inc      = wait_reg + TIMEOUT_W'(1);
    assign bit_inc       = bit_count_reg + BITCNT_W'(1);

    always_comb
    begin
        phase_next     = phase_reg;
        bit_count_next = bit_count_reg;
        extra_next     = extra_reg;
        shift_next     = shift_reg;
        wait_next      = wait_reg;
        chan_next      = chan_reg;
        found_next     = found_reg;
        done_next      = 1'b0;
        ok_next        = 1'b0;
        sample_next    = '0;
        if (q_item.kind != ITEM_TICK)
        begin
            // a start while a read runs is dropped
            if (phase_reg == PH_IDLE)
            begin
                if (q_item.kind == ITEM_BAD)
                begin
                    done_next = 1'b1;
                end
                else
                begin
                    chan_next      = q_item.channel;
                    wait_next      = '0;
                    bit_count_next = '0;
                    extra_next     = '0;
                    shift_next     = '0;
                    phase_next     = PH_WAIT;
                end
            end
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_WAIT:
                begin
                    if (!line)
                    begin
                        phase_next = PH_HIGH;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                        if (wait_inc >= timeout_reg)
                        begin
                            done_next  = 1'b1;
                            found_next = found_reg & ~chan_bit & CH_MASK;
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_HIGH:
                begin
                    phase_next = PH_LOW;
                end
                PH_LOW:
                begin
                    shift_next     = {shift_reg[SAMPLE_W-2:0], line};
                    bit_count_next = bit_inc;
                    if (bit_inc < BITCNT_W'(SAMPLE_W))
                    begin
                        phase_next = PH_HIGH;
                    end
                    else
                    begin
                        extra_next = EXTRA_W'(1);
                        phase_next = PH_XHIGH;
                    end
                end
                PH_XHIGH:
                begin
                    phase_next = PH_XLOW;
                end
                PH_XLOW:
                begin
                    if (extra_reg < pulses_for_gain(gain_reg))
                    begin
                        extra_next = extra_reg + EXTRA_W'(1);
                        phase_next = PH_XHIGH;
                    end
                    else
                    begin
                        done_next   = 1'b1;
                        ok_next     = 1'b1;
                        sample_next = shift_reg;
                        found_next  = (found_reg | chan_bit) & CH_MASK;
                        phase_next  = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
        clock_pins_next = (phase_next == PH_HIGH || phase_next == PH_XHIGH)
                        ? (chan_bit_next & CH_MASK) : '0;
        busy_next       = (phase_next != PH_IDLE);
        found_out_next  = found_next & CH_MASK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_count_reg <= '0;
            extra_reg     <= '0;
            shift_reg     <= '0;
            wait_reg      <= '0;
            chan_reg      <= '0;
            found_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (step)
            begin
                phase_reg     <= phase_next;
                bit_count_reg <= bit_count_next;
                extra_reg     <= extra_next;
                shift_reg     <= shift_next;
                wait_reg      <= wait_next;
                chan_reg      <= chan_next;
                found_reg     <= found_next;
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            clock_pins_reg <= clock_pins_next;
            busy_reg       <= busy_next;
            done_reg       <= done_next;
            ok_reg         <= ok_next;
            sample_reg     <= sample_next;
            found_out_reg  <= found_out_next;
        end
    end

    // configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg    <= GAIN_128;
            timeout_reg <= TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            unique case (cfg.index)
                CFG_GAIN:    gain_reg    <= cfg.data[GAIN_W-1:0];
                CFG_TIMEOUT: timeout_reg <= cfg.data[TIMEOUT_W-1:0];
                default:     gain_reg    <= gain_reg;
            endcase
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.clock_pins = clock_pins_reg;
    assign result.busy_res   = busy_reg;
    assign result.done_res   = done_reg;
    assign result.read_ok    = ok_reg;
    assign result.sample     = sample_reg;
    assign result.found_mask = found_out_reg;

`ifndef NO_ASSERTIONS
    a_ok_from_last_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        (step && ok_next) |-> (phase_reg == PH_XLOW))
        else $error("read finished outside the last extra pulse");

    a_ok_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && ok_reg) |-> done_reg)
        else $error("read_ok without done");

    a_idle_clock_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !busy_reg) |-> (clock_pins_reg == '0))
        else $error("clock driven while idle");

    a_step_fills_result: assert property (@(posedge clk) disable iff (!rst_n)
        step |=> out_valid_reg)
        else $error("processed word produced no result");

    a_bit_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        bit_count_reg <= BITCNT_W'(SAMPLE_W))
        else $error("bit count beyond word length");
`endif

endmodule

`default_nettype wire

// ----- bench/bridge_adc_serial_reader_unit_tb.sv -----
// testbench for the bridge converter serial reader: directed table, then checked random reads
`default_nettype none

module bridge_adc_serial_reader_unit_tb;
    import bars_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CHANNELS    = 3;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 60;
    localparam int LIMIT       = 300000;
    localparam int ROWS        = 14;

    localparam logic REQ_TICK  = 1'b0;
    localparam logic REQ_START = 1'b1;

    typedef struct packed {
        logic [PIN_W-1:0]    clocks;
        logic                busy;
        logic                done;
        logic                ok;
        logic [SAMPLE_W-1:0] smp;
        logic [PIN_W-1:0]    found;
    } status_t;

    typedef struct packed {
        logic              rt;
        logic [CHAN_W-1:0] ch;
        logic [PIN_W-1:0]  pins;
        logic              typed;
        status_t           want;
    } script_row_t;

    logic clk;
    logic rst_n;

    bars_req_if req_bus ();
    bars_res_if res_bus ();
    bars_cfg_if cfg_bus ();

    bridge_adc_serial_reader_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_bus),
        .result  (res_bus),
        .cfg     (cfg_bus)
    );

    // shadow of the reader state and its registers
    phase_t                m_phase;
    logic [BITCNT_W-1:0]   m_bits;
    logic [EXTRA_W-1:0]    m_extra;
    logic [SAMPLE_W-1:0]   m_shift;
    logic [TIMEOUT_W-1:0]  m_wait;
    logic [CHAN_W-1:0]     m_chan;
    logic [PIN_W-1:0]      m_found;
    gain_t                 m_gain;
    logic [TIMEOUT_W-1:0]  m_tmo;

    status_t     status_q[$];
    script_row_t script [ROWS];

    int idle_mode;
    int mismatches;
    int cycle_count;
    int n_words;
    int n_reads_ok;
    int n_timeouts;
    int n_rejects;
    int phase_words;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [EXTRA_W-1:0] gain_pulses(input gain_t g);
        case (g)
            GAIN_32: return 2'd2;
            GAIN_64: return 2'd3;
            default: return 2'd1;
        endcase
    endfunction

    function automatic status_t advance_reader(input logic rt, input logic [CHAN_W-1:0] ch,
                                               input logic [PIN_W-1:0] pins);
        status_t s;
        logic [PIN_W-1:0] sel;
        logic line;
        s = '0;
        sel = (m_chan < CHANNELS) ? (3'b001 << m_chan) : 3'b000;
        line = |(pins & sel);
        if (rt == REQ_START)
        begin
            if (m_phase == PH_IDLE)
            begin
                if (ch >= CHANNELS)
                begin
                    s.done = 1'b1;
                    n_rejects++;
                end
                else
                begin
                    m_chan  = ch;
                    m_wait  = '0;
                    m_bits  = '0;
                    m_extra = '0;
                    m_shift = '0;
                    m_phase = PH_WAIT;
                end
            end
        end
        else
        begin
            case (m_phase)
                PH_WAIT:
                begin
                    if (!line)
                        m_phase = PH_HIGH;
                    else
                    begin
                        m_wait = m_wait + 1'b1;
                        if (m_wait >= m_tmo)
                        begin
                            s.done  = 1'b1;
                            m_found = m_found & ~sel;
                            m_phase = PH_IDLE;
                            n_timeouts++;
                        end
                    end
                end
                PH_HIGH: m_phase = PH_LOW;
                PH_LOW:
                begin
                    m_shift = {m_shift[SAMPLE_W-2:0], line};
                    m_bits  = m_bits + 1'b1;
                    if (m_bits < SAMPLE_W)
                        m_phase = PH_HIGH;
                    else
                    begin
                        m_extra = 2'd1;
                        m_phase = PH_XHIGH;
                    end
                end
                PH_XHIGH: m_phase = PH_XLOW;
                PH_XLOW:
                begin
                    if (m_extra < gain_pulses(m_gain))
                    begin
                        m_extra = m_extra + 1'b1;
                        m_phase = PH_XHIGH;
                    end
                    else
                    begin
                        s.done  = 1'b1;
                        s.ok    = 1'b1;
                        s.smp   = m_shift;
                        m_found = m_found | sel;
                        m_phase = PH_IDLE;
                        n_reads_ok++;
                    end
                end
                default: m_phase = PH_IDLE;
            endcase
        end
        s.clocks = (m_phase == PH_HIGH || m_phase == PH_XHIGH) ? sel : 3'b000;
        s.busy   = (m_phase != PH_IDLE);
        s.found  = m_found;
        return s;
    endfunction

    // valid stays high across back-to-back words; it drops only on a gap or a drain
    task automatic send_word(input logic rt, input logic [CHAN_W-1:0] ch,
                             input logic [PIN_W-1:0] pins, input logic typed,
                             input status_t want);
        status_t got;
        int gap_pct;
        gap_pct = (idle_mode == 1) ? 60 : (idle_mode == 3) ? 26 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            req_bus.valid <= 1'b0;
            @(posedge clk);
        end
        req_bus.valid     <= 1'b1;
        req_bus.req_type  <= rt;
        req_bus.channel   <= ch;
        req_bus.data_pins <= pins;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        got = advance_reader(rt, ch, pins);
        status_q.push_back(typed ? want : got);
        n_words++;
        phase_words++;
    endtask

    task automatic tick(input logic [PIN_W-1:0] pins);
        send_word(REQ_TICK, 2'd0, pins, 1'b0, '0);
    endtask

    task automatic drain();
        req_bus.valid <= 1'b0;
        while (status_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic cfg_write(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        @(posedge clk);
        while (!cfg_bus.ready)
            @(posedge clk);
        if (idx == CFG_GAIN)
            m_gain = gain_t'(value[GAIN_W-1:0]);
        else
            m_tmo = value[TIMEOUT_W-1:0];
    endtask

    task automatic noise_burst(input int count);
        repeat (count)
            send_word(logic'($urandom_range(1)), CHAN_W'($urandom_range(3)),
                      PIN_W'($urandom_range(7)), 1'b0, '0);
    endtask

    // start, ticks with the line high (sometimes until the timeout), then clocked bits of a chosen pattern
    task automatic read_sequence(input bit truncate);
        logic [CHAN_W-1:0]   ch;
        logic [PIN_W-1:0]    sel;
        logic [SAMPLE_W-1:0] pattern;
        int hold;
        int eff_tmo;
        int span;
        int k;
        ch  = CHAN_W'($urandom_range(CHANNELS - 1));
        sel = 3'b001 << ch;
        case ($urandom_range(5))
            0: pattern = 24'h000000;
            1: pattern = 24'hFFFFFF;
            2: pattern = 24'h7FFFFF;
            3: pattern = 24'h800000;
            4: pattern = 24'h000001;
            default: pattern = SAMPLE_W'($urandom);
        endcase
        eff_tmo = (m_tmo == 0) ? 1 : int'(m_tmo);
        if (!truncate && eff_tmo <= 20 && $urandom_range(2) == 0)
            hold = eff_tmo + $urandom_range(1);
        else
            hold = $urandom_range(4);
        send_word(REQ_START, ch, PIN_W'($urandom_range(7)), 1'b0, '0);
        for (k = 0; k < hold; k++)
            tick(PIN_W'($urandom_range(7)) | sel);
        if (hold >= eff_tmo)
            return;
        tick(PIN_W'($urandom_range(7)) & ~sel);
        // samples land on the even ticks after the line was seen low
        span = truncate ? 49 + $urandom_range(2) : 48 + 2 * int'(gain_pulses(m_gain));
        for (k = 1; k <= span; k++)
        begin
            if (k <= 48 && k % 2 == 0)
                tick(pattern[SAMPLE_W - k / 2] ? (PIN_W'($urandom_range(7)) | sel)
                                               : (PIN_W'($urandom_range(7)) & ~sel));
            else
                tick(PIN_W'($urandom_range(7)));
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_bus.ready <= 1'b0;
        else if (idle_mode == 2)
            res_bus.ready <= ($urandom_range(99) >= 60);
        else if (idle_mode == 3)
            res_bus.ready <= ($urandom_range(99) >= 26);
        else
            res_bus.ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        status_t want;
        if (rst_n && res_bus.valid && res_bus.ready)
        begin
            if (status_q.size() == 0)
            begin
                $error("result word with nothing expected");
                mismatches++;
            end
            else
            begin
                want = status_q.pop_front();
                if (res_bus.clock_pins !== want.clocks)
                begin
                    $error("clock_pins expected %b got %b", want.clocks, res_bus.clock_pins);
                    mismatches++;
                end
                if (res_bus.busy_res !== want.busy)
                begin
                    $error("busy_res expected %b got %b", want.busy, res_bus.busy_res);
                    mismatches++;
                end
                if (res_bus.done_res !== want.done)
                begin
                    $error("done_res expected %b got %b", want.done, res_bus.done_res);
                    mismatches++;
                end
                if (res_bus.read_ok !== want.ok)
                begin
                    $error("read_ok expected %b got %b", want.ok, res_bus.read_ok);
                    mismatches++;
                end
                if (res_bus.sample !== want.smp)
                begin
                    $error("sample expected %h got %h", want.smp, res_bus.sample);
                    mismatches++;
                end
                if (res_bus.found_mask !== want.found)
                begin
                    $error("found_mask expected %b got %b", want.found, res_bus.found_mask);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT)
        begin
            $display("bridge_adc_serial_reader_unit verification failed");
            $finish;
        end
    end

    initial
    begin
        int p;
        int r;
        rst_n             <= 1'b0;
        req_bus.valid     <= 1'b0;
        req_bus.req_type  <= REQ_TICK;
        req_bus.channel   <= '0;
        req_bus.data_pins <= '0;
        cfg_bus.valid     <= 1'b0;
        cfg_bus.index     <= CFG_GAIN;
        cfg_bus.data      <= '0;
        idle_mode   = 0;
        mismatches  = 0;
        cycle_count = 0;
        n_words     = 0;
        n_reads_ok  = 0;
        n_timeouts  = 0;
        n_rejects   = 0;
        m_phase = PH_IDLE;
        m_bits  = '0;
        m_extra = '0;
        m_shift = '0;
        m_wait  = '0;
        m_chan  = '0;
        m_found = '0;
        m_gain  = GAIN_128;
        m_tmo   = TIMEOUT_RESET;

        // idle ticks and bad channels have obvious results; the rest come from the shadow
        script[0]  = '{REQ_TICK,  2'd0, 3'b111, 1'b1, status_t'('0)};
        script[1]  = '{REQ_START, 2'd3, 3'b000, 1'b1,
                       status_t'{3'b000, 1'b0, 1'b1, 1'b0, 24'd0, 3'b000}};
        script[2]  = '{REQ_START, 2'd3, 3'b111, 1'b1,
                       status_t'{3'b000, 1'b0, 1'b1, 1'b0, 24'd0, 3'b000}};
        script[3]  = '{REQ_TICK,  2'd3, 3'b101, 1'b1, status_t'('0)};
        script[4]  = '{REQ_START, 2'd2, 3'b111, 1'b0, status_t'('0)};
        script[5]  = '{REQ_TICK,  2'd0, 3'b111, 1'b0, status_t'('0)};
        script[6]  = '{REQ_START, 2'd0, 3'b000, 1'b0, status_t'('0)};
        script[7]  = '{REQ_TICK,  2'd1, 3'b011, 1'b0, status_t'('0)};
        script[8]  = '{REQ_TICK,  2'd2, 3'b111, 1'b0, status_t'('0)};
        script[9]  = '{REQ_TICK,  2'd0, 3'b100, 1'b0, status_t'('0)};
        script[10] = '{REQ_START, 2'd3, 3'b000, 1'b0, status_t'('0)};
        script[11] = '{REQ_TICK,  2'd0, 3'b000, 1'b0, status_t'('0)};
        script[12] = '{REQ_TICK,  2'd0, 3'b011, 1'b0, status_t'('0)};
        script[13] = '{REQ_TICK,  2'd3, 3'b110, 1'b0, status_t'('0)};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (p = 0; p < PHASES; p++)
        begin
            if (p > 0)
            begin
                drain();
                idle_mode = p % 4;
                case (p)
                    1: begin cfg_write(CFG_GAIN, {14'h3FFF, GAIN_32});
                             cfg_write(CFG_TIMEOUT, 16'hFFFF); end
                    2: begin cfg_write(CFG_GAIN, {14'h2AAA, GAIN_64});
                             cfg_write(CFG_TIMEOUT, 16'd1); end
                    3: begin cfg_write(CFG_GAIN, {14'h1555, GAIN_128_B});
                             cfg_write(CFG_TIMEOUT, 16'd0); end
                    4: begin cfg_write(CFG_GAIN, {14'h0000, GAIN_128});
                             cfg_write(CFG_TIMEOUT, 16'd5); end
                    5: begin cfg_write(CFG_GAIN, {14'($urandom), GAIN_64});
                             cfg_write(CFG_TIMEOUT, 16'd3); end
                    6: begin cfg_write(CFG_GAIN, {14'($urandom), GAIN_32});
                             cfg_write(CFG_TIMEOUT, 16'd12); end
                    default: begin cfg_write(CFG_GAIN, 16'($urandom));
                             cfg_write(CFG_TIMEOUT, 16'($urandom_range(20, 1))); end
                endcase
                cfg_bus.valid <= 1'b0;
            end
            phase_words = 0;
            if (p == 0)
                for (r = 0; r < ROWS; r++)
                    send_word(script[r].rt, script[r].ch, script[r].pins,
                              script[r].typed, script[r].want);
            // tick on any read left over from before, possibly under a new gain, so that it can finish
            repeat (8) tick(PIN_W'($urandom_range(7)));
            while (phase_words < PHASE_WORDS)
            begin
                if ($urandom_range(99) < 75)
                    read_sequence(1'b0);
                else
                    noise_burst($urandom_range(12, 3));
            end
            // often end mid-way through the extra pulses so the next gain write can land inside a read
            read_sequence(1'b1);
        end

        drain();
        repeat (10) @(posedge clk);
        $display("run covered %0d request words over %0d register settings and idling mixes",
                 n_words, PHASES);
        $display("reads completed %0d, timed out %0d, rejected on bad channel %0d",
                 n_reads_ok, n_timeouts, n_rejects);
        if (mismatches == 0 && status_q.size() == 0)
            $display("bridge_adc_serial_reader_unit verification clean");
        else
            $display("bridge_adc_serial_reader_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire

// ----- bridge_adc_serial_reader_unit.f -----
rtl/bars_pkg.sv
rtl/bars_req_if.sv
rtl/bars_res_if.sv
rtl/bars_cfg_if.sv
rtl/bars_front.sv
rtl/bars_queue.sv
rtl/bars_back.sv
rtl/bridge_adc_serial_reader_unit.sv
bench/bridge_adc_serial_reader_unit_tb.sv
